// ===== src/ptt_pkg.sv =====
// shared types, codes and constants for the periodic timer table
package ptt_pkg;

	localparam int SLOTS_DEF = 8;

	localparam int KEY_W   = 16;
	localparam int PER_W   = 24;
	localparam int TIME_W  = 32;
	localparam int WAIT_W  = 16;
	localparam int OP_W    = 2;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [WAIT_W-1:0] IDLE_WAIT_RST = 16'd1000;
	localparam logic [WAIT_W-1:0] MIN_WAIT_RST  = 16'd5;

	// opcodes
	localparam logic [OP_W-1:0] OP_ADD = 2'd0;
	localparam logic [OP_W-1:0] OP_DEL = 2'd1;
	localparam logic [OP_W-1:0] OP_RUN = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WAIT   = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_REARMED   = 3'd0;
	localparam logic [STAT_W-1:0] ST_ADDED     = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_WAIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_WAIT  = 2'd1;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [PER_W-1:0]  period;
		logic [TIME_W-1:0] due;
	} entry_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [STAT_W-1:0] status;
		logic [KEY_W-1:0]  fired_key;
		logic [WAIT_W-1:0] wait_ms;
		logic              last;
	} res_t;

endpackage

// ===== src/ptt_ram.sv =====
// generic single-write, single-read ram with registered read data
module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/ptt_ctrl.sv =====
// sequencer: scans the timer ram, read-modify-write of entries, produces results
module ptt_ctrl import ptt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CNT_W = $clog2(SLOTS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   opcode,
	input  logic [KEY_W-1:0]  timer_key,
	input  logic [PER_W-1:0]  period_ms,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [WAIT_W-1:0] idle_wait,
	input  logic [WAIT_W-1:0] min_wait,
	input  logic              out_free,
	output logic              emit,
	output res_t              res,
	output logic              ram_we,
	output logic [IDX_W-1:0]  ram_waddr,
	output entry_t            ram_wdata,
	output logic [IDX_W-1:0]  ram_raddr,
	input  entry_t            ram_rdata
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_MOVE = 3'd2;
	localparam logic [2:0] S_STAT = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;

	logic [2:0]        state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [IDX_W-1:0]  slot_q, slot_d;
	logic [OP_W-1:0]   op_q, op_d;
	logic [KEY_W-1:0]  key_q, key_d;
	logic [PER_W-1:0]  per_q, per_d;
	logic [TIME_W-1:0] now_q, now_d;
	logic [WAIT_W-1:0] wait_q, wait_d;
	logic [STAT_W-1:0] status_q, status_d;

	logic              last_slot;
	logic              key_hit;
	logic              fire;
	logic [TIME_W-1:0] left;
	logic              left_lt;
	logic [TIME_W-1:0] add_due;
	logic [TIME_W-1:0] run_due;
	logic [IDX_W-1:0]  tail;
	logic [IDX_W-1:0]  idx_next;

	assign in_ready  = (state_q == S_IDLE);
	assign last_slot = (CNT_W'(idx_q) == count_q - CNT_W'(1));
	assign key_hit   = (ram_rdata.key == key_q);
	assign fire      = (now_q >= ram_rdata.due);
	assign run_due   = now_q + TIME_W'(ram_rdata.period);
	assign add_due   = now_q + TIME_W'(per_q);
	// a re-armed entry has exactly its period left
	assign left      = fire ? TIME_W'(ram_rdata.period) : ram_rdata.due - now_q;
	assign left_lt   = (left < TIME_W'(wait_q));
	assign tail      = IDX_W'(count_q - CNT_W'(1));
	assign idx_next  = idx_q + IDX_W'(1);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		slot_d    = slot_q;
		op_d      = op_q;
		key_d     = key_q;
		per_d     = per_q;
		now_d     = now_q;
		wait_d    = wait_q;
		status_d  = status_q;
		emit      = 1'b0;
		res       = '0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '{key: key_q, period: per_q, due: add_due};
		ram_raddr = idx_q;

		case (state_q)
			S_IDLE: begin
				// slot 0 is read ahead so its data is ready in the first scan cycle
				ram_raddr = '0;
				if (in_valid) begin
					op_d   = opcode;
					key_d  = timer_key;
					per_d  = period_ms;
					now_d  = now_ms;
					idx_d  = '0;
					wait_d = idle_wait;
					if (opcode inside {OP_ADD, OP_DEL, OP_RUN}) begin
						if (count_q != '0) begin
							state_d = S_SCAN;
						end else if (opcode == OP_ADD) begin
							status_d = ST_ADDED;
							state_d  = S_STAT;
						end else if (opcode == OP_DEL) begin
							status_d = ST_NOT_FOUND;
							state_d  = S_STAT;
						end else begin
							state_d = S_WAIT;
						end
					end
				end
			end

			S_SCAN: begin
				case (op_q)
					OP_ADD: begin
						if (key_hit) begin
							ram_we    = 1'b1;
							ram_waddr = idx_q;
							status_d  = ST_REARMED;
							state_d   = S_STAT;
						end else if (last_slot) begin
							status_d = (count_q == CNT_W'(SLOTS)) ? ST_FULL : ST_ADDED;
							state_d  = S_STAT;
						end else begin
							idx_d     = idx_next;
							ram_raddr = idx_next;
						end
					end
					OP_DEL: begin
						if (key_hit) begin
							slot_d    = idx_q;
							ram_raddr = tail;
							state_d   = S_MOVE;
						end else if (last_slot) begin
							status_d = ST_NOT_FOUND;
							state_d  = S_STAT;
						end else begin
							idx_d     = idx_next;
							ram_raddr = idx_next;
						end
					end
					default: begin
						// run scan: hold on this slot while a fire transaction cannot go out
						if (!(fire && !out_free)) begin
							if (fire) begin
								ram_we        = 1'b1;
								ram_waddr     = idx_q;
								ram_wdata     = '{key: ram_rdata.key,
									period: ram_rdata.period, due: run_due};
								emit          = 1'b1;
								res.kind      = KIND_FIRE;
								res.fired_key = ram_rdata.key;
							end
							if (left_lt) begin
								wait_d = left[WAIT_W-1:0];
							end
							if (last_slot) begin
								state_d = S_WAIT;
							end else begin
								idx_d     = idx_next;
								ram_raddr = idx_next;
							end
						end
					end
				endcase
			end

			S_MOVE: begin
				// last entry moves into the freed slot
				ram_raddr = tail;
				ram_we    = 1'b1;
				ram_waddr = slot_q;
				ram_wdata = ram_rdata;
				count_d   = count_q - CNT_W'(1);
				status_d  = ST_REMOVED;
				state_d   = S_STAT;
			end

			S_STAT: begin
				if (out_free) begin
					emit       = 1'b1;
					res.kind   = KIND_STATUS;
					res.status = status_q;
					res.last   = 1'b1;
					if (status_q == ST_ADDED) begin
						ram_we    = 1'b1;
						ram_waddr = IDX_W'(count_q);
						count_d   = count_q + CNT_W'(1);
					end
					state_d = S_IDLE;
				end
			end

			S_WAIT: begin
				if (out_free) begin
					emit        = 1'b1;
					res.kind    = KIND_WAIT;
					res.wait_ms = (wait_q < min_wait) ? min_wait : wait_q;
					res.last    = 1'b1;
					state_d     = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		slot_q   <= slot_d;
		op_q     <= op_d;
		key_q    <= key_d;
		per_q    <= per_d;
		now_q    <= now_d;
		wait_q   <= wait_d;
		status_q <= status_d;
	end

endmodule

// ===== src/ptt_obuf.sv =====
// output register: holds one result transaction until it is taken
module ptt_obuf import ptt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              emit,
	input  res_t              res,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [KIND_W-1:0] kind,
	output logic [STAT_W-1:0] status,
	output logic [KEY_W-1:0]  fired_key,
	output logic [WAIT_W-1:0] wait_ms,
	output logic              last
);

	logic out_valid_q;
	res_t res_q;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign kind      = res_q.kind;
	assign status    = res_q.status;
	assign fired_key = res_q.fired_key;
	assign wait_ms   = res_q.wait_ms;
	assign last      = res_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res;
		end
	end

endmodule

// ===== src/periodic_timer_table_unit.sv =====
// top level of the periodic timer table: config registers, timer ram, sequencer, output register
//
//   channel  handshake               payload
//   in       in_valid / in_ready     opcode, timer_key, period_ms, now_ms
//   out      out_valid / out_ready   kind, status, fired_key, wait_ms, last
//   cfg      cfg_we                  cfg_index, cfg_wdata
//
// one operation at a time; the scan reads one ram slot per cycle unless the output stalls it
// (read data is registered); a run scans every entry, add and delete stop early on a key match
// and delete reads the tail entry in an extra step; an unused opcode is taken with no result
// reset clears the entry count and loads the config register defaults; the ram is not cleared
// a full output register stalls a run scan in place, input is taken only between operations
module periodic_timer_table_unit import ptt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OP_W-1:0]      opcode,
	input  logic [KEY_W-1:0]     timer_key,
	input  logic [PER_W-1:0]     period_ms,
	input  logic [TIME_W-1:0]    now_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [KIND_W-1:0]    kind,
	output logic [STAT_W-1:0]    status,
	output logic [KEY_W-1:0]     fired_key,
	output logic [WAIT_W-1:0]    wait_ms,
	output logic                 last,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WAIT_W-1:0]    cfg_wdata
);

	logic [WAIT_W-1:0] idle_wait_q;
	logic [WAIT_W-1:0] min_wait_q;
	logic              out_free;
	logic              emit;
	res_t              res;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	entry_t            ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_wait_q <= IDLE_WAIT_RST;
			min_wait_q  <= MIN_WAIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDLE_WAIT: idle_wait_q <= cfg_wdata;
				CFG_MIN_WAIT:  min_wait_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ptt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ptt_ctrl #(
		.SLOTS (SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.timer_key (timer_key),
		.period_ms (period_ms),
		.now_ms    (now_ms),
		.idle_wait (idle_wait_q),
		.min_wait  (min_wait_q),
		.out_free  (out_free),
		.emit      (emit),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	ptt_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.status    (status),
		.fired_key (fired_key),
		.wait_ms   (wait_ms),
		.last      (last)
	);

endmodule

// ===== tb/tb_periodic_timer_table_unit.sv =====
// testbench for the periodic timer table: table predictor, random traffic and result checking
module tb_periodic_timer_table_unit;
	import ptt_pkg::*;

	localparam int SLOTS         = SLOTS_DEF;
	localparam int KEY_POOL      = 12;
	localparam int PHASE_OPS     = 35;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int LIMIT_CYCLES  = 200000;

	// opcode 3 is not decoded by the block
	localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
	// register indexes past the two real registers
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [OP_W-1:0]      opcode    = OP_ADD;
	logic [KEY_W-1:0]     timer_key = '0;
	logic [PER_W-1:0]     period_ms = '0;
	logic [TIME_W-1:0]    now_ms    = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [KIND_W-1:0]    kind;
	logic [STAT_W-1:0]    status;
	logic [KEY_W-1:0]     fired_key;
	logic [WAIT_W-1:0]    wait_ms;
	logic                 last;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_IDLE_WAIT;
	logic [WAIT_W-1:0]    cfg_wdata = '0;

	// predicted table contents and registers
	int                tbl_count = 0;
	logic [KEY_W-1:0]  tbl_key    [SLOTS];
	logic [PER_W-1:0]  tbl_period [SLOTS];
	logic [TIME_W-1:0] tbl_due    [SLOTS];
	logic [WAIT_W-1:0] idle_wait = IDLE_WAIT_RST;
	logic [WAIT_W-1:0] min_wait  = MIN_WAIT_RST;

	res_t pending_results[$];

	logic [KEY_W-1:0]  key_pool [KEY_POOL];
	logic [TIME_W-1:0] clock_ms = '0;
	bit no_idle  = 1'b0;
	bit hold_req = 1'b0;

	int n_cycles  = 0;
	int n_errors  = 0;
	int n_ops     = 0;
	int n_ignored = 0;
	int n_checked = 0;
	int n_fired   = 0;
	int n_full    = 0;
	int n_holds   = 0;

	periodic_timer_table_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.timer_key (timer_key),
		.period_ms (period_ms),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.status    (status),
		.fired_key (fired_key),
		.wait_ms   (wait_ms),
		.last      (last),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > LIMIT_CYCLES) begin
			$display("%0t: timed out with %0d results outstanding", $time,
				pending_results.size());
			$display("tb_periodic_timer_table_unit: done, errors");
			$finish;
		end
	end

	function automatic void expect_result(logic [KIND_W-1:0] k, logic [STAT_W-1:0] st,
			logic [KEY_W-1:0] fk, logic [WAIT_W-1:0] w);
		res_t r;
		r.kind      = k;
		r.status    = st;
		r.fired_key = fk;
		r.wait_ms   = w;
		r.last      = 1'b0;
		pending_results.push_back(r);
	endfunction

	// update the predicted table for one accepted transaction and queue its results
	function automatic void apply_timer_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
			logic [PER_W-1:0] per, logic [TIME_W-1:0] now);
		int slot;
		int tail;
		logic [TIME_W-1:0] shortest;
		logic [TIME_W-1:0] left;
		slot = -1;
		for (int i = 0; i < tbl_count; i++)
			if (slot < 0 && tbl_key[i] == key)
				slot = i;
		case (op)
			OP_ADD: begin
				if (slot >= 0) begin
					tbl_period[slot] = per;
					tbl_due[slot]    = now + TIME_W'(per);
					expect_result(KIND_STATUS, ST_REARMED, '0, '0);
				end else if (tbl_count >= SLOTS) begin
					n_full++;
					expect_result(KIND_STATUS, ST_FULL, '0, '0);
				end else begin
					tbl_key[tbl_count]    = key;
					tbl_period[tbl_count] = per;
					tbl_due[tbl_count]    = now + TIME_W'(per);
					tbl_count++;
					expect_result(KIND_STATUS, ST_ADDED, '0, '0);
				end
			end
			OP_DEL: begin
				if (slot >= 0) begin
					// tail entry moves into the freed slot
					tail = tbl_count - 1;
					tbl_key[slot]    = tbl_key[tail];
					tbl_period[slot] = tbl_period[tail];
					tbl_due[slot]    = tbl_due[tail];
					tbl_count        = tail;
					expect_result(KIND_STATUS, ST_REMOVED, '0, '0);
				end else
					expect_result(KIND_STATUS, ST_NOT_FOUND, '0, '0);
			end
			OP_RUN: begin
				shortest = TIME_W'(idle_wait);
				for (int i = 0; i < tbl_count; i++) begin
					if (now >= tbl_due[i]) begin
						tbl_due[i] = now + TIME_W'(tbl_period[i]);
						n_fired++;
						expect_result(KIND_FIRE, ST_REARMED, tbl_key[i], '0);
					end
					left = tbl_due[i] - now;
					if (left < shortest)
						shortest = left;
				end
				if (shortest < TIME_W'(min_wait))
					shortest = TIME_W'(min_wait);
				expect_result(KIND_WAIT, ST_REARMED, '0, shortest[WAIT_W-1:0]);
			end
			default: ;
		endcase
		if (op != OP_IGNORED)
			pending_results[pending_results.size()-1].last = 1'b1;
	endfunction

	function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
			n_errors++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		res_t head;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected, actual kind %0d status %0d",
					$time, kind, status);
				$display("  key %0h wait %0d last %0b", fired_key, wait_ms, last);
				n_errors++;
			end else begin
				head = pending_results.pop_front();
				check_field("kind", 32'(head.kind), 32'(kind));
				check_field("status", 32'(head.status), 32'(status));
				check_field("fired_key", 32'(head.fired_key), 32'(fired_key));
				check_field("wait_ms", 32'(head.wait_ms), 32'(wait_ms));
				check_field("last", 32'(head.last), 32'(last));
				n_checked++;
			end
		end
	end

	// output side: random back-pressure, or a long hold-off on request
	initial begin : ready_driver
		int held;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
				n_holds++;
				hold_req = 1'b0;
			end else
				out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 30);
		end
	end

	// offer one transaction, return at the edge where it is accepted
	task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [PER_W-1:0] per, input logic [TIME_W-1:0] now);
		int gap;
		gap = 0;
		if (!no_idle)
			while ($urandom_range(99) < 30)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		timer_key <= key;
		period_ms <= per;
		now_ms    <= now;
		do
			@(posedge clk);
		while (!in_ready);
		apply_timer_op(op, key, per, now);
		n_ops++;
		if (op == OP_IGNORED)
			n_ignored++;
	endtask

	// stop offering and let every outstanding result come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WAIT_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IDLE_WAIT)
			idle_wait = data;
		else if (idx == CFG_MIN_WAIT)
			min_wait = data;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [WAIT_W-1:0] idle, input logic [WAIT_W-1:0] floor_ms);
		drain_results();
		write_reg(CFG_IDLE_WAIT, idle);
		write_reg(CFG_MIN_WAIT, floor_ms);
	endtask

	task automatic test_reset_defaults();
		send_op(OP_RUN, '0, '0, '0);
		send_op(OP_ADD, 16'h0000, '0, '0);
		// zero period expires at once and pulls the wait down to the floor
		send_op(OP_RUN, '0, '0, '0);
	endtask

	task automatic test_table_edges();
		// due time wraps past the top of the time range
		send_op(OP_ADD, 16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
		for (int i = 1; i <= 6; i++)
			send_op(OP_ADD, KEY_W'(i), PER_W'(100 * i), 32'd10);
		send_op(OP_ADD, 16'h0007, 24'd50, 32'd10);
		send_op(OP_ADD, 16'h0001, 24'd50, 32'd20);
		send_op(OP_RUN, '0, '0, 32'hFFFF_FFFF);
		send_op(OP_DEL, 16'h1234, '0, '0);
		// middle slot gets refilled from the tail
		send_op(OP_DEL, 16'h0003, '0, '0);
		send_op(OP_DEL, 16'hFFFF, '0, '0);
		send_op(OP_IGNORED, 16'hA5A5, 24'h5A_5A5A, 32'h1234_5678);
		send_op(OP_RUN, '0, '0, 32'd1000);
	endtask

	task automatic test_config_extremes();
		set_config(16'd1, 16'd0);
		send_op(OP_RUN, '0, '0, 32'h8000_0000);
		// floor above the idle wait wins
		set_config(16'd1, 16'hFFFF);
		send_op(OP_RUN, '0, '0, 32'h8000_0100);
		drain_results();
		write_reg(CFG_SPARE_A, 16'hFFFF);
		write_reg(CFG_SPARE_B, 16'h0000);
		set_config(16'hFFFF, 16'd0);
		send_op(OP_RUN, '0, '0, 32'h8000_0200);
	endtask

	task automatic test_random_traffic();
		int pick;
		logic [OP_W-1:0]   op;
		logic [KEY_W-1:0]  key;
		logic [PER_W-1:0]  per;
		logic [TIME_W-1:0] now;
		for (int ph = 0; ph < 4; ph++) begin
			set_config(WAIT_W'(($urandom_range(99) < 20) ? $urandom_range(1, 65535)
				: $urandom_range(50, 3000)),
				WAIT_W'(($urandom_range(99) < 15) ? $urandom_range(0, 65535)
				: $urandom_range(0, 40)));
			no_idle = (ph == 1);
			// let the time base run across the 32-bit wrap
			if (ph == 2)
				clock_ms = 32'hFFFF_F000;
			for (int k = 0; k < PHASE_OPS; k++) begin
				pick = $urandom_range(99);
				if (pick < 40)
					op = OP_ADD;
				else if (pick < 58)
					op = OP_DEL;
				else if (pick < 96)
					op = OP_RUN;
				else
					op = OP_IGNORED;
				if ($urandom_range(99) < 85)
					key = key_pool[$urandom_range(KEY_POOL - 1)];
				else
					key = KEY_W'($urandom);
				pick = $urandom_range(99);
				if (pick < 10)
					per = '0;
				else if (pick < 20)
					per = PER_W'($urandom);
				else
					per = PER_W'($urandom_range(1, 1500));
				if ($urandom_range(99) < 8)
					now = $urandom;
				else begin
					clock_ms += $urandom_range(0, 400);
					now = clock_ms;
				end
				send_op(op, key, per, now);
			end
		end
		no_idle = 1'b0;
	endtask

	task automatic test_backpressure();
		while (tbl_count > 0)
			send_op(OP_DEL, tbl_key[tbl_count - 1], '0, clock_ms);
		for (int i = 0; i < SLOTS; i++)
			send_op(OP_ADD, KEY_W'(16'hC000 + i), '0, clock_ms);
		// every run now gives a full set of fire results; the first ones meet a stalled output
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++) begin
			clock_ms += $urandom_range(0, 50);
			send_op(OP_RUN, '0, '0, clock_ms);
		end
		drain_results();
	endtask

	initial begin
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = KEY_W'($urandom_range(0, 65535));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_table_edges();
		test_config_extremes();
		test_random_traffic();
		test_backpressure();
		drain_results();
		$display("covered %0d transactions (%0d with unused opcode), %0d results checked",
			n_ops, n_ignored, n_checked);
		$display("  %0d timer fires, %0d adds refused on a full table, %0d output hold-offs",
			n_fired, n_full, n_holds);
		if (n_errors == 0)
			$display("tb_periodic_timer_table_unit: done, clean");
		else
			$display("tb_periodic_timer_table_unit: done, errors");
		$finish;
	end

endmodule

// ===== periodic_timer_table_unit.f =====
src/ptt_pkg.sv
src/ptt_ram.sv
src/ptt_ctrl.sv
src/ptt_obuf.sv
src/periodic_timer_table_unit.sv
tb/tb_periodic_timer_table_unit.sv
